// ===== rtl/swhsr_pkg.sv =====
// Package with the types and constants shared by the single-wire sensor reader.
package swhsr_pkg;

  localparam int FRAME_BITS = 40;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);

  localparam logic [15:0] START_LOW_RST = 16'd2000;
  localparam logic [7:0]  RELEASE_RST   = 8'd30;
  localparam logic [9:0]  RESP_TO_RST   = 10'd200;
  localparam logic [9:0]  BIT_TO_RST    = 10'd100;
  localparam logic [9:0]  HIGH_CAP_RST  = 10'd100;
  localparam logic [9:0]  ONE_THR_RST   = 10'd10;
  localparam logic [23:0] MIN_INT_RST   = 24'd2000000;
  localparam logic [23:0] SINCE_MAX     = 24'hFF_FFFF;

  localparam logic [2:0] REG_START_LOW = 3'd0;
  localparam logic [2:0] REG_RELEASE   = 3'd1;
  localparam logic [2:0] REG_RESP_TO   = 3'd2;
  localparam logic [2:0] REG_BIT_TO    = 3'd3;
  localparam logic [2:0] REG_HIGH_CAP  = 3'd4;
  localparam logic [2:0] REG_ONE_THR   = 3'd5;
  localparam logic [2:0] REG_MIN_INT   = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_START     = 3'd1,
    PH_RELEASE   = 3'd2,
    PH_RESP_LOW  = 3'd3,
    PH_RESP_HIGH = 3'd4,
    PH_RESP_LOW2 = 3'd5,
    PH_BIT_WAIT  = 3'd6,
    PH_BIT_HIGH  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SOON    = 3'd1,
    ST_NO_RESP     = 3'd2,
    ST_STUCK_LOW   = 3'd3,
    ST_STUCK_HIGH  = 3'd4,
    ST_BIT_TIMEOUT = 3'd5,
    ST_CHECKSUM    = 3'd6
  } status_t;

  typedef struct packed {
    logic cmd;
    logic line_level;
  } swhsr_in_t;

  typedef struct packed {
    logic               drive_low;
    logic               done_res;
    status_t            status;
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
  } swhsr_out_t;

endpackage

// ===== rtl/single_wire_humidity_sensor_reader_top.sv =====
// Top level of the single-wire humidity and temperature sensor reader.
// The result of an item is registered in the output register when the item is accepted.
// One item per cycle while not stalled; the phase sequencer updates once per accepted item.
// An item is taken whenever the output register is empty or being emptied in the same cycle.
// Reset is synchronous and active low; it restores the register defaults and the idle phase.
// After reset a start request is refused until min_int_r - 1 items have been accepted.
module single_wire_humidity_sensor_reader_top
  import swhsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  swhsr_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output swhsr_out_t  out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  logic [15:0] start_low_r;
  logic [7:0]  release_r;
  logic [9:0]  resp_to_r;
  logic [9:0]  bit_to_r;
  logic [9:0]  high_cap_r;
  logic [9:0]  one_thr_r;
  logic [23:0] min_int_r;

  phase_t             phase_r, phase_nxt;
  logic [15:0]        ticks_r, ticks_nxt;
  logic [CNT_W-1:0]   bits_r, bits_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [23:0]        since_r, since_nxt;
  logic               out_valid_r;
  swhsr_out_t         out_r, out_nxt;

  logic               accept;
  logic [15:0]        tick_inc;
  logic [23:0]        since_inc;
  logic               fin;
  status_t            fin_st;
  logic               bit_end;
  logic [15:0]        bit_ticks;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [CNT_W-1:0]   bits_inc;
  logic [7:0]         csum;
  logic [15:0]        temp_word;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign tick_inc  = ticks_r + 16'd1;
  assign since_inc = (since_r < SINCE_MAX) ? since_r + 24'd1 : since_r;
  assign bits_inc  = bits_r + CNT_W'(1);
  assign frame_shift = {frame_r[FRAME_BITS-2:0], (bit_ticks > {6'd0, one_thr_r})};
  assign csum = frame_shift[39:32] + frame_shift[31:24] + frame_shift[23:16]
              + frame_shift[15:8];
  assign temp_word = frame_shift[23:8];

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    bits_nxt  = bits_r;
    frame_nxt = frame_r;
    since_nxt = since_inc;
    fin       = 1'b0;
    fin_st    = ST_OK;
    bit_end   = 1'b0;
    bit_ticks = ticks_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_data.cmd) begin
          if (since_inc < min_int_r) begin
            fin    = 1'b1;
            fin_st = ST_TOO_SOON;
          end else begin
            ticks_nxt = '0;
            bits_nxt  = '0;
            frame_nxt = '0;
            phase_nxt = (start_low_r == 16'd0) ? PH_RELEASE : PH_START;
          end
        end
      end
      PH_START: begin
        ticks_nxt = tick_inc;
        if (tick_inc >= start_low_r) begin
          phase_nxt = PH_RELEASE;
          ticks_nxt = '0;
        end
      end
      PH_RELEASE: begin
        ticks_nxt = tick_inc;
        if (tick_inc >= {8'd0, release_r}) begin
          phase_nxt = PH_RESP_LOW;
          ticks_nxt = '0;
        end
      end
      PH_RESP_LOW: begin
        if (!in_data.line_level) begin
          phase_nxt = PH_RESP_HIGH;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = tick_inc;
          if (tick_inc > {6'd0, resp_to_r}) begin
            fin    = 1'b1;
            fin_st = ST_NO_RESP;
          end
        end
      end
      PH_RESP_HIGH: begin
        if (in_data.line_level) begin
          phase_nxt = PH_RESP_LOW2;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = tick_inc;
          if (tick_inc > {6'd0, resp_to_r}) begin
            fin    = 1'b1;
            fin_st = ST_STUCK_LOW;
          end
        end
      end
      PH_RESP_LOW2: begin
        if (!in_data.line_level) begin
          phase_nxt = PH_BIT_WAIT;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = tick_inc;
          if (tick_inc > {6'd0, resp_to_r}) begin
            fin    = 1'b1;
            fin_st = ST_STUCK_HIGH;
          end
        end
      end
      PH_BIT_WAIT: begin
        if (in_data.line_level) begin
          ticks_nxt = '0;
          if (high_cap_r == 10'd0) begin
            bit_end   = 1'b1;
            bit_ticks = '0;
          end else begin
            phase_nxt = PH_BIT_HIGH;
          end
        end else begin
          ticks_nxt = tick_inc;
          if (tick_inc > {6'd0, bit_to_r}) begin
            fin    = 1'b1;
            fin_st = ST_BIT_TIMEOUT;
          end
        end
      end
      PH_BIT_HIGH: begin
        if (!in_data.line_level) begin
          bit_end = 1'b1;
        end else begin
          ticks_nxt = tick_inc;
          bit_ticks = tick_inc;
          if (tick_inc >= {6'd0, high_cap_r}) begin
            bit_end = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        ticks_nxt = '0;
      end
    endcase
    if (bit_end) begin
      frame_nxt = frame_shift;
      bits_nxt  = bits_inc;
      ticks_nxt = '0;
      if (bits_inc >= CNT_W'(FRAME_BITS)) begin
        fin = 1'b1;
        if (csum != frame_shift[7:0]) begin
          fin_st = ST_CHECKSUM;
        end else begin
          fin_st    = ST_OK;
          since_nxt = '0;
        end
      end else begin
        phase_nxt = PH_BIT_WAIT;
      end
    end
    if (fin) begin
      phase_nxt = PH_IDLE;
      ticks_nxt = '0;
    end
  end

  always_comb begin
    out_nxt             = '0;
    out_nxt.drive_low   = (phase_nxt == PH_START);
    out_nxt.done_res    = fin;
    out_nxt.status      = fin ? fin_st : ST_OK;
    if (fin && fin_st == ST_OK) begin
      out_nxt.humidity    = frame_shift[39:24];
      out_nxt.temperature = temp_word[15] ? $signed(16'd0 - {1'b0, temp_word[14:0]})
                                          : $signed(temp_word);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_r <= START_LOW_RST;
      release_r   <= RELEASE_RST;
      resp_to_r   <= RESP_TO_RST;
      bit_to_r    <= BIT_TO_RST;
      high_cap_r  <= HIGH_CAP_RST;
      one_thr_r   <= ONE_THR_RST;
      min_int_r   <= MIN_INT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_LOW: start_low_r <= cfg_wdata[15:0];
        REG_RELEASE:   release_r   <= cfg_wdata[7:0];
        REG_RESP_TO:   resp_to_r   <= cfg_wdata[9:0];
        REG_BIT_TO:    bit_to_r    <= cfg_wdata[9:0];
        REG_HIGH_CAP:  high_cap_r  <= cfg_wdata[9:0];
        REG_ONE_THR:   one_thr_r   <= cfg_wdata[9:0];
        REG_MIN_INT:   min_int_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      ticks_r     <= '0;
      bits_r      <= '0;
      frame_r     <= '0;
      since_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        ticks_r <= ticks_nxt;
        bits_r  <= bits_nxt;
        frame_r <= frame_nxt;
        since_r <= since_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule
